// ===== design/ssfe_pkg.sv =====
// ssfe_pkg: shared types, constants and frame helpers for the seven-segment
// frame encoder. No dependencies.
package ssfe_pkg;

    localparam int NUM_DIGITS = 4;

    localparam logic [15:0] CLEAR_FRAME = 16'hFFFF;
    localparam logic [3:0]  FILL_NIBBLE = 4'hF;
    localparam logic        NO_DOT      = 1'b1;

    localparam logic [15:0] LIMIT_1D = 16'd10;
    localparam logic [15:0] LIMIT_2D = 16'd100;
    localparam logic [15:0] LIMIT_3D = 16'd1000;
    localparam logic [15:0] LIMIT_4D = 16'd10000;

    // reciprocal constants, exact for every value below 10000
    localparam logic [15:0] RECIP_10   = 16'd52429;  // shift 19
    localparam logic [12:0] RECIP_100  = 13'd5243;   // shift 19
    localparam logic [13:0] RECIP_1000 = 14'd8389;   // shift 23

    typedef logic [3:0] t_digit;
    typedef logic [1:0] t_pos;

    typedef struct packed {
        t_digit [NUM_DIGITS-1:0] digit;  // index 0 is units
        logic   [2:0]            ndig;   // 0 means out of range
    } t_item;

    function automatic logic [6:0] seg_bits(input t_digit d);
        logic [6:0] s;
        begin
            case (d)
                4'd0: s = 7'h01;
                4'd1: s = 7'h4F;
                4'd2: s = 7'h12;
                4'd3: s = 7'h06;
                4'd4: s = 7'h4C;
                4'd5: s = 7'h24;
                4'd6: s = 7'h20;
                4'd7: s = 7'h0F;
                4'd8: s = 7'h00;
                4'd9: s = 7'h0C;
                default: s = 7'h7F;
            endcase
            seg_bits = s;
        end
    endfunction

    function automatic logic [15:0] digit_frame(input t_digit d, input t_pos pos);
        logic [3:0] sel;
        begin
            sel = 4'b0001 << pos;
            digit_frame = {sel, FILL_NIBBLE, seg_bits(d), NO_DOT};
        end
    endfunction

endpackage

// ===== design/ssfe_split.sv =====
// ssfe_split: input register stage; takes one word, splits it into decimal
// digits and a digit count. Depends on ssfe_pkg.
module ssfe_split import ssfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_number_in,
    input  logic        i_take,
    output logic        o_busy,
    output logic        o_valid,
    output t_item       o_item
);

    logic        r_valid;
    logic [15:0] r_num;
    logic [12:0] r_q10;
    logic [9:0]  r_q100;
    logic [6:0]  r_q1000;
    logic [2:0]  r_ndig;

    logic        load;
    logic [31:0] prod10;
    logic [28:0] prod100;
    logic [29:0] prod1000;
    logic [2:0]  n_ndig;
    logic [15:0] rem_u;
    logic [12:0] rem_t;
    logic [9:0]  rem_h;

    assign o_busy = r_valid && !i_take;
    assign load   = i_start && !o_busy;

    assign prod10   = 32'(i_number_in) * 32'(RECIP_10);
    assign prod100  = 29'(i_number_in) * 29'(RECIP_100);
    assign prod1000 = 30'(i_number_in) * 30'(RECIP_1000);

    always_comb begin
        if (i_number_in < LIMIT_1D) begin
            n_ndig = 3'd1;
        end else if (i_number_in < LIMIT_2D) begin
            n_ndig = 3'd2;
        end else if (i_number_in < LIMIT_3D) begin
            n_ndig = 3'd3;
        end else if (i_number_in < LIMIT_4D) begin
            n_ndig = 3'd4;
        end else begin
            n_ndig = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_num   <= i_number_in;
            r_q10   <= prod10[31:19];
            r_q100  <= prod100[28:19];
            r_q1000 <= prod1000[29:23];
            r_ndig  <= n_ndig;
        end
    end

    // remainders: x - 10*q, times ten as two shifts
    assign rem_u = r_num - {r_q10, 3'b000} - {2'b00, r_q10, 1'b0};
    assign rem_t = r_q10 - {r_q100, 3'b000} - {2'b00, r_q100, 1'b0};
    assign rem_h = r_q100 - {r_q1000, 3'b000} - {2'b00, r_q1000, 1'b0};

    assign o_valid         = r_valid;
    assign o_item.digit[0] = rem_u[3:0];
    assign o_item.digit[1] = rem_t[3:0];
    assign o_item.digit[2] = rem_h[3:0];
    assign o_item.digit[3] = r_q1000[3:0];
    assign o_item.ndig     = r_ndig;

endmodule

// ===== design/ssfe_frames.sv =====
// ssfe_frames: frame sequencer and result register; emits the clear frame
// and then the digit frames of one item, one per cycle. Depends on ssfe_pkg.
module ssfe_frames import ssfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    output logic        o_valid,
    output logic [15:0] o_frame,
    output logic        o_is_last
);

    logic        r_act;
    logic [2:0]  r_step;
    t_item       r_item;
    logic        r_out_valid;
    logic [15:0] r_frame;
    logic        r_last;

    logic        last;
    logic [2:0]  pos_wide;
    t_pos        pos;
    logic [15:0] n_frame;

    assign last   = (r_step == r_item.ndig);
    assign o_take = !r_act || last;

    // short numbers go units first, longer ones most significant first
    always_comb begin
        if (r_item.ndig <= 3'd2) begin
            pos_wide = r_step - 3'd1;
        end else begin
            pos_wide = r_item.ndig - r_step;
        end
        pos = pos_wide[1:0];
        if (r_step == 3'd0) begin
            n_frame = CLEAR_FRAME;
        end else begin
            n_frame = digit_frame(r_item.digit[pos], pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_act;
            if (o_take) begin
                r_act  <= i_valid;
                r_step <= 3'd0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_item <= i_item;
        end
        r_frame <= n_frame;
        r_last  <= last;
    end

    assign o_valid   = r_out_valid;
    assign o_frame   = r_frame;
    assign o_is_last = r_last;

endmodule

// ===== design/seven_segment_frame_encoder_top.sv =====
// seven_segment_frame_encoder_top: top level of the seven-segment frame
// encoder. Depends on ssfe_pkg, ssfe_split and ssfe_frames.
//
// Usage:
//   A word (i_number_in) is taken at a rising edge where start is high and
//   busy is low. For each word the block emits a clear frame of all ones,
//   then one digit frame per significant decimal digit for 0..9999 (units
//   then tens for one or two digits, most significant first otherwise);
//   10000 and above gives only the clear frame. o_is_last marks the final
//   frame of a word's run.
//   Each frame sits on o_frame for one cycle with o_valid high; the receiver
//   cannot stall, so frames leave one per cycle with no gap inside a run.
//   When the sequencer is free, a word passes the input register, the
//   sequencer register and the frame register before its clear frame
//   appears. The sequencer emits one frame per cycle, the clear frame and
//   then one per digit. One word waits in the input stage; busy is high
//   while it is full and the active sequencer is not on its last frame.
//   Reset (synchronous, active low) drops any word in flight and clears
//   busy and o_valid.
module seven_segment_frame_encoder_top import ssfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [15:0] i_number_in,
    output logic        busy,
    output logic        o_valid,
    output logic [15:0] o_frame,
    output logic        o_is_last
);

    logic  split_valid;
    logic  take;
    t_item item;

    ssfe_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_number_in (i_number_in),
        .i_take      (take),
        .o_busy      (busy),
        .o_valid     (split_valid),
        .o_item      (item)
    );

    ssfe_frames u_frames (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (split_valid),
        .i_item    (item),
        .o_take    (take),
        .o_valid   (o_valid),
        .o_frame   (o_frame),
        .o_is_last (o_is_last)
    );

    // a run continues without a gap until its last frame
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |=> o_valid)
        else $error("frame run broken before last frame");

    // every run opens with the clear frame
    a_run_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!$past(o_valid) || $past(o_is_last)) |-> o_frame == CLEAR_FRAME)
        else $error("run does not start with clear frame");

    // digit frames select exactly one digit
    a_digit_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame != CLEAR_FRAME |-> $onehot(o_frame[15:12]))
        else $error("digit frame select not one-hot");

    // reset leaves nothing in flight
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("outputs active after reset");

endmodule

// ===== sim/tb_seven_segment_frame_encoder_top.sv =====
// tb_seven_segment_frame_encoder_top: self-checking testbench for the seven-segment
// frame encoder. Needs ssfe_pkg and seven_segment_frame_encoder_top; drives directed
// then random numbers; checks every frame against typed frames or its own predictor.
`timescale 1ns / 1ps

module tb_seven_segment_frame_encoder_top import ssfe_pkg::*;;

    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RANDOM   = 200;
    localparam int CYCLE_LIMIT  = 100000;

    // active-low segment codes for digits 0..9, bit 6 is segment a, bit 0 is segment g
    localparam logic [0:9][6:0] SEGMENT_CODE = {
        7'h01, 7'h4F, 7'h12, 7'h06, 7'h4C, 7'h24, 7'h20, 7'h0F, 7'h00, 7'h0C
    };

    typedef struct packed {
        logic [15:0] frame;
        logic        is_last;
    } t_frame;

    // typed_count of zero means the row is checked by the predictor
    typedef struct packed {
        logic [15:0]       number;
        logic [2:0]        typed_count;
        logic [0:4][15:0]  typed_frames;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [15:0] i_number_in;
    logic        busy;
    logic        o_valid;
    logic [15:0] o_frame;
    logic        o_is_last;

    t_frame pending_frames[$];
    int     error_count;
    int     cycle_count;
    int     words_sent;
    int     clear_only_words;
    int     frames_checked;

    t_directed_row directed_rows [0:NUM_DIRECTED-1] = '{
        '{16'd0,     3'd2, {16'hFFFF, 16'h1F03, 16'h0, 16'h0, 16'h0}},
        '{16'd8,     3'd2, {16'hFFFF, 16'h1F01, 16'h0, 16'h0, 16'h0}},
        '{16'd9,     3'd0, 80'h0},
        '{16'd10,    3'd0, 80'h0},
        '{16'd42,    3'd0, 80'h0},
        '{16'd99,    3'd0, 80'h0},
        '{16'd100,   3'd0, 80'h0},
        '{16'd505,   3'd0, 80'h0},
        '{16'd999,   3'd0, 80'h0},
        '{16'd1000,  3'd0, 80'h0},
        '{16'd1234,  3'd0, 80'h0},
        '{16'd5678,  3'd0, 80'h0},
        '{16'd9090,  3'd0, 80'h0},
        '{16'd9999,  3'd5, {16'hFFFF, 16'h8F19, 16'h4F19, 16'h2F19, 16'h1F19}},
        '{16'd10000, 3'd1, {16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{16'd65535, 3'd1, {16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{16'd32768, 3'd0, 80'h0},
        '{16'd16383, 3'd0, 80'h0},
        '{16'd3607,  3'd0, 80'h0},
        '{16'd7,     3'd0, 80'h0}
    };

    seven_segment_frame_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_number_in (i_number_in),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_frame     (o_frame),
        .o_is_last   (o_is_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] segment_frame(input int digit, input int pos);
        logic [3:0] select;
        select = 4'b0001 << pos;
        return {select, 4'hF, SEGMENT_CODE[digit], 1'b1};
    endfunction

    // queue the frames one number produces: clear first, then digit frames
    function automatic void predict_frames(input logic [15:0] value);
        int n;
        int count;
        int order[4];
        int digit[4];
        n = value;
        digit[0] = n % 10;
        digit[1] = (n / 10) % 10;
        digit[2] = (n / 100) % 10;
        digit[3] = (n / 1000) % 10;
        if (n >= 10000) begin
            pending_frames.push_back('{CLEAR_FRAME, 1'b1});
            return;
        end
        pending_frames.push_back('{CLEAR_FRAME, 1'b0});
        // one and two digit numbers go units first, longer ones go top down
        if (n < 10) begin
            count = 1;
            order = '{0, 0, 0, 0};
        end else if (n < 100) begin
            count = 2;
            order = '{0, 1, 0, 0};
        end else if (n < 1000) begin
            count = 3;
            order = '{2, 1, 0, 0};
        end else begin
            count = 4;
            order = '{3, 2, 1, 0};
        end
        for (int k = 0; k < count; k++) begin
            pending_frames.push_back('{segment_frame(digit[order[k]], order[k]),
                                       k == count - 1});
        end
    endfunction

    function automatic logic [15:0] pick_number();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: return 16'($urandom_range(0, 9));
            1: return 16'($urandom_range(10, 99));
            2: return 16'($urandom_range(100, 999));
            7: return 16'($urandom_range(10000, 65535));
            8: return 16'($urandom);
            9: begin
                case ($urandom_range(0, 7))
                    0: return 16'd9;
                    1: return 16'd10;
                    2: return 16'd99;
                    3: return 16'd100;
                    4: return 16'd999;
                    5: return 16'd1000;
                    6: return 16'd9999;
                    default: return 16'd10000;
                endcase
            end
            default: return 16'($urandom_range(1000, 9999));
        endcase
    endfunction

    // holds start high until the word is taken
    task automatic send_word(input logic [15:0] value);
        start <= 1'b1;
        i_number_in <= value;
        do @(posedge i_clk); while (busy);
        words_sent++;
        if (value >= 16'd10000) begin
            clear_only_words++;
        end
    endtask

    // most gaps are empty or short, a few are long, some stretches have none
    task automatic idle_gap(input bit back_to_back);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (back_to_back || roll < 55) begin
            gap = 0;
        end else if (roll < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            i_number_in <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_valid) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected word: frame %h is_last %b", o_frame, o_is_last);
                error_count++;
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (o_frame !== want.frame) begin
                    $error("frame mismatch: field frame expected %h actual %h",
                           want.frame, o_frame);
                    error_count++;
                end
                if (o_is_last !== want.is_last) begin
                    $error("frame mismatch: field is_last expected %b actual %b",
                           want.is_last, o_is_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d frames outstanding",
                 cycle_count, pending_frames.size());
        $display("seven_segment_frame_encoder_top regression: fail");
        $finish;
    end

    initial begin
        t_directed_row row;
        logic [15:0]   value;
        error_count = 0;
        cycle_count = 0;
        words_sent = 0;
        clear_only_words = 0;
        frames_checked = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_number_in <= 16'h0000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = directed_rows[i];
            send_word(row.number);
            if (row.typed_count == 0) begin
                predict_frames(row.number);
            end else begin
                for (int k = 0; k < row.typed_count; k++) begin
                    pending_frames.push_back('{row.typed_frames[k],
                                               k == row.typed_count - 1});
                end
            end
            idle_gap(1'b0);
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            value = pick_number();
            send_word(value);
            predict_frames(value);
            idle_gap((i / 32) % 3 == 2);
        end
        start <= 1'b0;

        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d words (%0d out of range only clear), checked %0d frames",
                 words_sent, clear_only_words, frames_checked);
        if (error_count == 0) begin
            $display("seven_segment_frame_encoder_top regression: pass");
        end else begin
            $display("seven_segment_frame_encoder_top regression: fail");
        end
        $finish;
    end

endmodule
